>>> sv/mvs_pkg.sv
// Package for the mouse velocity to stick unit.
// Holds field widths, register indexes and the sequencer state type.
package mvs_pkg;

    localparam int VEL_W  = 16;
    localparam int DT_W   = 16;
    localparam int STICK_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SENS_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SENS_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_X  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_Y  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TAU    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_THR    = 3'd5;

    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_MX   = 12'b0000_0000_0010,
        S_MY   = 12'b0000_0000_0100,
        S_MT   = 12'b0000_0000_1000,
        S_GATE = 12'b0000_0001_0000,
        S_DM   = 12'b0000_0010_0000,
        S_DL   = 12'b0000_0100_0000,
        S_DIV  = 12'b0000_1000_0000,
        S_MS   = 12'b0001_0000_0000,
        S_MN   = 12'b0010_0000_0000,
        S_MO   = 12'b0100_0000_0000,
        S_OUT  = 12'b1000_0000_0000
    } t_state;

endpackage

>>> sv/mvs_in_if.sv
// Input channel of the mouse velocity to stick unit.
// Depends on mvs_pkg for field widths.
interface mvs_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [mvs_pkg::VEL_W-1:0]    vel_x;
    logic signed [mvs_pkg::VEL_W-1:0]    vel_y;
    logic        [mvs_pkg::DT_W-1:0]     elapsed_ms;

    modport source (output valid, output vel_x, output vel_y, output elapsed_ms, input ready);
    modport sink   (input valid, input vel_x, input vel_y, input elapsed_ms, output ready);
endinterface

>>> sv/mvs_out_if.sv
// Output channel of the mouse velocity to stick unit.
// Depends on mvs_pkg for field widths.
interface mvs_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [mvs_pkg::STICK_W-1:0]  stick_x;
    logic signed [mvs_pkg::STICK_W-1:0]  stick_y;

    modport source (output valid, output stick_x, output stick_y, input ready);
    modport sink   (input valid, input stick_x, input stick_y, output ready);
endinterface

>>> sv/mouse_velocity_to_stick_unit.sv
// Mouse velocity to stick unit: noise gate, smoother, gain, clamp, minimum.
// Steps: noise gate on squared speed, smoother (multiply and 33-step divide per axis),
// scaling per axis, output load. Gated words go straight to the output load; zero dt
// holds and zero tau copies the smoother, with no divide; a full output register stalls.
// One shared 33x25 multiplier and one divider step are reused; no new word until output load.
// Synchronous active-low reset restores register defaults and clears state.
module mouse_velocity_to_stick_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    mvs_in_if.sink                              i_in,
    mvs_out_if.source                           o_out,
    input  logic                                i_cfg_we,
    input  logic [mvs_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [mvs_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    mvs_pkg::t_state r_state;

    logic [15:0] r_sens_x, r_sens_y;
    logic [14:0] r_min_x, r_min_y;
    logic [9:0]  r_tau;
    logic [14:0] r_thr;

    logic        r_moving;
    logic [31:0] r_sx, r_sy;

    logic signed [15:0] r_vx, r_vy;
    logic [15:0] r_dt;
    logic [31:0] r_sq;
    logic        r_axis;
    logic        r_neg;
    logic [16:0] r_rem;
    logic [32:0] r_quo;
    logic [5:0]  r_cnt;
    logic [15:0] r_rx, r_ry;
    logic [57:0] r_prod;

    logic        r_ov;
    logic [15:0] r_ox, r_oy;

    logic [32:0] mul_a;
    logic [24:0] mul_b;

    function automatic logic [16:0] mag16(input logic [15:0] v);
        mag16 = v[15] ? (17'd0 - {1'b1, v}) : {1'b0, v};
    endfunction

    function automatic logic [31:0] mag32(input logic [31:0] v);
        mag32 = v[31] ? (32'd0 - v) : v;
    endfunction

    // shared operands of the current step
    logic [31:0] s_cur;
    logic [15:0] v_cur;
    logic [32:0] diff;
    logic [32:0] adiff;
    logic [16:0] den;
    logic [31:0] ax, ay;
    logic [14:0] p_cur;
    logic [15:0] sens_cur;
    logic [40:0] m_clip;
    logic [41:0] m_rnd;
    logic [24:0] m24;
    logic [41:0] num;
    logic        sat;
    logic [54:0] pos_t, neg_t;
    logic [15:0] axis_res;
    logic [49:0] div_n;
    logic [17:0] rem_sh;
    logic        ge;
    logic [16:0] rem_n;
    logic [32:0] quo_n;
    logic [33:0] s_upd;
    logic [35:0] sq16;
    logic [33:0] t2x9;
    logic        gate_ok;

    always_comb begin
        s_cur    = r_axis ? r_sy : r_sx;
        v_cur    = r_axis ? r_vy : r_vx;
        diff     = {v_cur[15], v_cur, 16'd0} - {s_cur[31], s_cur};
        adiff    = diff[32] ? (33'd0 - diff) : diff;
        den      = {7'd0, r_tau} + {1'b0, r_dt};
        ax       = mag32(r_sx);
        ay       = mag32(r_sy);
        if (r_axis) begin
            p_cur    = (ay >= ax) ? r_min_y : 15'd0;
            sens_cur = r_sens_y;
        end else begin
            p_cur    = (ax >= ay) ? r_min_x : 15'd0;
            sens_cur = r_sens_x;
        end
        m_clip   = (r_prod[47:0] > 48'h100_0000_0000) ? 41'h100_0000_0000 : r_prod[40:0];
        m_rnd    = {1'b0, m_clip} + 42'h8000;
        m24      = m_rnd[40:16];
        num      = {3'd0, p_cur, 24'd0} + {1'b0, r_prod[40:0]};
        sat      = (num >= 42'h80_0000_0000);
        pos_t    = {1'b0, num[38:0], 15'd0} - {16'd0, num[38:0]} + 55'h40_0000_0000;
        neg_t    = {1'b0, num[38:0], 15'd0} + 55'h40_0000_0000;
        if (s_cur[31]) begin
            axis_res = sat ? 16'h8000 : (16'd0 - neg_t[54:39]);
        end else begin
            axis_res = sat ? 16'h7FFF : pos_t[54:39];
        end
        div_n    = r_prod[49:0] + {34'd0, den[16:1]};
        rem_sh   = {r_rem, r_quo[32]};
        ge       = (rem_sh >= {1'b0, den});
        rem_n    = ge ? (rem_sh[16:0] - den) : rem_sh[16:0];
        quo_n    = {r_quo[31:0], ge};
        s_upd    = r_neg ? ({2'd0, s_cur} - {1'b0, quo_n}) : ({2'd0, s_cur} + {1'b0, quo_n});
        sq16     = {r_sq, 4'd0};
        t2x9     = {1'b0, r_prod[29:0], 3'd0} + {4'd0, r_prod[29:0]};
        if (r_thr == 15'd0) begin
            gate_ok = (r_sq != 32'd0);
        end else if (r_moving) begin
            gate_ok = (sq16 >= {2'd0, t2x9});
        end else begin
            gate_ok = ({2'd0, r_sq} > r_prod[33:0]);
        end
    end

    // multiplier operand select
    always_comb begin
        mul_a = 33'd0;
        mul_b = 25'd0;
        case (r_state)
            mvs_pkg::S_MX: begin
                mul_a = {16'd0, mag16(r_vx)};
                mul_b = {8'd0, mag16(r_vx)};
            end
            mvs_pkg::S_MY: begin
                mul_a = {16'd0, mag16(r_vy)};
                mul_b = {8'd0, mag16(r_vy)};
            end
            mvs_pkg::S_MT: begin
                mul_a = {18'd0, r_thr};
                mul_b = {10'd0, r_thr};
            end
            mvs_pkg::S_DM: begin
                mul_a = adiff;
                mul_b = {9'd0, r_dt};
            end
            mvs_pkg::S_MS: begin
                mul_a = {1'b0, mag32(s_cur)};
                mul_b = {9'd0, sens_cur};
            end
            mvs_pkg::S_MN: begin
                mul_a = 33'd32768 - {18'd0, p_cur};
                mul_b = m24;
            end
            default: begin
                mul_a = 33'd0;
                mul_b = 25'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sens_x <= 16'd4096;
            r_sens_y <= 16'd4096;
            r_min_x  <= 15'd0;
            r_min_y  <= 15'd0;
            r_tau    <= 10'd8;
            r_thr    <= 15'd61;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mvs_pkg::REG_SENS_X: r_sens_x <= i_cfg_data;
                mvs_pkg::REG_SENS_Y: r_sens_y <= i_cfg_data;
                mvs_pkg::REG_MIN_X:  r_min_x  <= i_cfg_data[14:0];
                mvs_pkg::REG_MIN_Y:  r_min_y  <= i_cfg_data[14:0];
                mvs_pkg::REG_TAU:    r_tau    <= i_cfg_data[9:0];
                mvs_pkg::REG_THR:    r_thr    <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mvs_pkg::S_IDLE;
            r_moving <= 1'b0;
            r_sx     <= 32'd0;
            r_sy     <= 32'd0;
            r_ov     <= 1'b0;
            r_axis   <= 1'b0;
            r_cnt    <= 6'd0;
        end else begin
            if (r_ov && o_out.ready && r_state != mvs_pkg::S_OUT) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                mvs_pkg::S_IDLE: begin
                    if (i_in.valid) begin
                        r_vx    <= i_in.vel_x;
                        r_vy    <= i_in.vel_y;
                        r_dt    <= i_in.elapsed_ms;
                        r_state <= mvs_pkg::S_MX;
                    end
                end
                mvs_pkg::S_MX: begin
                    r_state <= mvs_pkg::S_MY;
                end
                mvs_pkg::S_MY: begin
                    r_sq    <= r_prod[31:0];
                    r_state <= mvs_pkg::S_MT;
                end
                mvs_pkg::S_MT: begin
                    r_sq    <= r_sq + r_prod[31:0];
                    r_state <= mvs_pkg::S_GATE;
                end
                mvs_pkg::S_GATE: begin
                    r_axis <= 1'b0;
                    if (!gate_ok) begin
                        // drop motion below the gate
                        r_moving <= 1'b0;
                        r_sx     <= 32'd0;
                        r_sy     <= 32'd0;
                        r_rx     <= 16'd0;
                        r_ry     <= 16'd0;
                        r_state  <= mvs_pkg::S_OUT;
                    end else begin
                        r_moving <= 1'b1;
                        if (r_tau == 10'd0) begin
                            r_sx    <= {r_vx, 16'd0};
                            r_sy    <= {r_vy, 16'd0};
                            r_state <= mvs_pkg::S_MS;
                        end else if (r_dt == 16'd0) begin
                            r_state <= mvs_pkg::S_MS;
                        end else begin
                            r_state <= mvs_pkg::S_DM;
                        end
                    end
                end
                mvs_pkg::S_DM: begin
                    r_neg   <= diff[32];
                    r_state <= mvs_pkg::S_DL;
                end
                mvs_pkg::S_DL: begin
                    r_rem   <= div_n[49:33];
                    r_quo   <= div_n[32:0];
                    r_cnt   <= 6'd33;
                    r_state <= mvs_pkg::S_DIV;
                end
                mvs_pkg::S_DIV: begin
                    r_rem <= rem_n;
                    r_quo <= quo_n;
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd1) begin
                        if (r_axis) begin
                            r_sy    <= s_upd[31:0];
                            r_axis  <= 1'b0;
                            r_state <= mvs_pkg::S_MS;
                        end else begin
                            r_sx    <= s_upd[31:0];
                            r_axis  <= 1'b1;
                            r_state <= mvs_pkg::S_DM;
                        end
                    end
                end
                mvs_pkg::S_MS: begin
                    if (s_cur == 32'd0) begin
                        // zero state gives zero even on the dominant axis
                        if (r_axis) begin
                            r_ry    <= 16'd0;
                            r_state <= mvs_pkg::S_OUT;
                        end else begin
                            r_rx    <= 16'd0;
                            r_axis  <= 1'b1;
                        end
                    end else begin
                        r_state <= mvs_pkg::S_MN;
                    end
                end
                mvs_pkg::S_MN: begin
                    r_state <= mvs_pkg::S_MO;
                end
                mvs_pkg::S_MO: begin
                    if (r_axis) begin
                        r_ry    <= axis_res;
                        r_state <= mvs_pkg::S_OUT;
                    end else begin
                        r_rx    <= axis_res;
                        r_axis  <= 1'b1;
                        r_state <= mvs_pkg::S_MS;
                    end
                end
                mvs_pkg::S_OUT: begin
                    // hold until the output register is free
                    if (!r_ov || o_out.ready) begin
                        r_ov    <= 1'b1;
                        r_ox    <= r_rx;
                        r_oy    <= r_ry;
                        r_state <= mvs_pkg::S_IDLE;
                    end
                end
                default: begin
                    r_state <= mvs_pkg::S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready    = (r_state == mvs_pkg::S_IDLE);
    assign o_out.valid   = r_ov;
    assign o_out.stick_x = r_ox;
    assign o_out.stick_y = r_oy;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_state == mvs_pkg::S_MX)
        else $error("accepted word did not start the sequence");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == mvs_pkg::S_DIV |-> {1'b0, r_rem} < {1'b0, den})
        else $error("divider remainder out of range");

    a_rest_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_moving |-> r_sx == 32'd0 && r_sy == 32'd0)
        else $error("smoother state nonzero at rest");

    a_load_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_state == mvs_pkg::S_OUT))
        else $error("output loaded outside the output step");

endmodule
